>>> design/psag_pkg.sv
// Shared widths, codes and item types of the periodic stencil address generator.
package psag_pkg;

	localparam int unsigned COORD_W    = 10;
	localparam int unsigned SIZE_W     = 11;
	localparam int unsigned COMP_W     = 7;
	localparam int unsigned HALF_W     = 3;
	localparam int unsigned OFS_W      = 37;
	localparam int unsigned REG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 11;
	localparam int unsigned KIND_W     = 2;
	localparam int unsigned AXIS_W     = 2;
	localparam int unsigned POS_W      = 4;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_SIZE_X       = 3'd0,
		REG_SIZE_Y       = 3'd1,
		REG_SIZE_Z       = 3'd2,
		REG_SCALAR_WIDTH = 3'd3,
		REG_VECTOR_WIDTH = 3'd4,
		REG_STENCIL_HALF = 3'd5
	} reg_idx_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_PAST    = 2'd0,
		KIND_NOW     = 2'd1,
		KIND_STENCIL = 2'd2,
		KIND_CORNER  = 2'd3
	} kind_t;

	typedef enum logic [AXIS_W-1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_PAST,
		PH_NOW,
		PH_STENCIL,
		PH_CORNER
	} seq_phase_t;

	typedef struct packed {
		logic [COORD_W-1:0] x_coord;
		logic [COORD_W-1:0] y_coord;
		logic [COORD_W-1:0] z_coord;
		logic               time_slot;
	} site_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [AXIS_W-1:0] axis;
		logic [POS_W-1:0]  position;
		logic [OFS_W-1:0]  scalar_offset;
		logic [OFS_W-1:0]  vector_offset;
		logic              range_error;
		logic              last;
	} result_t;

	typedef struct packed {
		logic [REG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_write_t;

	// per-result control that rides along the address pipeline
	typedef struct packed {
		kind_t            kind;
		axis_t            axis;
		logic [POS_W-1:0] position;
		logic             slot;
		logic             range_error;
		logic             last;
	} req_meta_t;

endpackage

>>> design/psag_stream_if.sv
// Valid/ready channel carrying one item of a given payload type.
interface psag_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> design/psag_cfg_regs.sv
// Configuration register file with saturation to the supported ranges.
module psag_cfg_regs #(
	parameter int unsigned MAX_EXTENT     = 1024,
	parameter int unsigned MAX_HALF       = 4,
	parameter int unsigned MAX_COMPONENTS = 64,
	localparam int unsigned EW = $clog2(MAX_EXTENT + 1),
	localparam int unsigned MW = $clog2(MAX_COMPONENTS + 1),
	localparam int unsigned HW = $clog2(MAX_HALF + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	psag_stream_if.sink          cfg,
	output logic [2:0][EW-1:0]   extent,
	output logic [MW-1:0]        scalar_w,
	output logic [MW-1:0]        vector_w,
	output logic [HW-1:0]        half
);

	localparam int unsigned CW  = (EW > psag_pkg::SIZE_W) ? EW : psag_pkg::SIZE_W;
	localparam int unsigned CMW = (MW > psag_pkg::COMP_W) ? MW : psag_pkg::COMP_W;
	localparam int unsigned CHW = (HW > psag_pkg::HALF_W) ? HW : psag_pkg::HALF_W;

	logic [2:0][psag_pkg::SIZE_W-1:0] size_q;
	logic [psag_pkg::COMP_W-1:0]      sw_q;
	logic [psag_pkg::COMP_W-1:0]      vw_q;
	logic [psag_pkg::HALF_W-1:0]      half_q;

	logic [2:0][CW-1:0] size_raw;
	logic [CMW-1:0]     sw_raw;
	logic [CMW-1:0]     vw_raw;
	logic [CHW-1:0]     half_raw;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= {3{psag_pkg::SIZE_W'(16)}};
			sw_q   <= psag_pkg::COMP_W'(1);
			vw_q   <= psag_pkg::COMP_W'(1);
			half_q <= psag_pkg::HALF_W'(1);
		end else if (cfg.valid) begin
			unique case (psag_pkg::reg_idx_t'(cfg.payload.index))
				psag_pkg::REG_SIZE_X: begin
					size_q[0] <= cfg.payload.data[psag_pkg::SIZE_W-1:0];
				end
				psag_pkg::REG_SIZE_Y: begin
					size_q[1] <= cfg.payload.data[psag_pkg::SIZE_W-1:0];
				end
				psag_pkg::REG_SIZE_Z: begin
					size_q[2] <= cfg.payload.data[psag_pkg::SIZE_W-1:0];
				end
				psag_pkg::REG_SCALAR_WIDTH: begin
					sw_q <= cfg.payload.data[psag_pkg::COMP_W-1:0];
				end
				psag_pkg::REG_VECTOR_WIDTH: begin
					vw_q <= cfg.payload.data[psag_pkg::COMP_W-1:0];
				end
				psag_pkg::REG_STENCIL_HALF: begin
					half_q <= cfg.payload.data[psag_pkg::HALF_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// zero counts as one, values above the maximum saturate
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			size_raw[a] = CW'(size_q[a]);
			if (size_raw[a] == '0) begin
				extent[a] = EW'(1);
			end else if (size_raw[a] > CW'(MAX_EXTENT)) begin
				extent[a] = EW'(MAX_EXTENT);
			end else begin
				extent[a] = EW'(size_raw[a]);
			end
		end
		sw_raw   = CMW'(sw_q);
		vw_raw   = CMW'(vw_q);
		half_raw = CHW'(half_q);
		if (sw_raw == '0) begin
			scalar_w = MW'(1);
		end else if (sw_raw > CMW'(MAX_COMPONENTS)) begin
			scalar_w = MW'(MAX_COMPONENTS);
		end else begin
			scalar_w = MW'(sw_raw);
		end
		if (vw_raw == '0) begin
			vector_w = MW'(1);
		end else if (vw_raw > CMW'(MAX_COMPONENTS)) begin
			vector_w = MW'(MAX_COMPONENTS);
		end else begin
			vector_w = MW'(vw_raw);
		end
		if (half_raw == '0) begin
			half = HW'(1);
		end else if (half_raw > CHW'(MAX_HALF)) begin
			half = HW'(MAX_HALF);
		end else begin
			half = HW'(half_raw);
		end
	end

endmodule

>>> design/psag_prep.sv
// Per-site front end: bit-serial coordinate remainder, then walk back by S.
module psag_prep #(
	parameter int unsigned MAX_EXTENT = 1024,
	parameter int unsigned MAX_HALF   = 4,
	localparam int unsigned EW = $clog2(MAX_EXTENT + 1),
	localparam int unsigned HW = $clog2(MAX_HALF + 1)
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	psag_stream_if.sink                           site,
	input  logic [2:0][EW-1:0]                    extent,
	input  logic [HW-1:0]                         half,
	output logic                                  prep_valid,
	input  logic                                  prep_take,
	output logic [2:0][psag_pkg::COORD_W-1:0]     prep_coord,
	output logic [2:0][EW-1:0]                    prep_start,
	output logic                                  prep_slot,
	output logic                                  prep_err
);

	localparam int unsigned CRD_W   = psag_pkg::COORD_W;
	localparam int unsigned PW      = (CRD_W > EW) ? CRD_W : EW;
	localparam int unsigned CNT_MAX = (CRD_W > MAX_HALF) ? CRD_W : MAX_HALF;
	localparam int unsigned CNT_W   = (CNT_MAX > 1) ? $clog2(CNT_MAX) : 1;

	// control
	logic             busy_q;
	logic             div_q;
	logic             fin_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pv_q;

	// working payload
	logic [2:0][EW-1:0]    rem_q;
	logic [2:0][CRD_W-1:0] dvd_q;
	logic [2:0][CRD_W-1:0] crd_q;
	logic                  slot_q;
	logic                  err_q;

	// handoff slot payload
	logic [2:0][CRD_W-1:0] pc_q;
	logic [2:0][EW-1:0]    pw_q;
	logic                  ps_q;
	logic                  pe_q;

	logic [2:0][CRD_W-1:0] crd_in;
	logic [2:0][EW-1:0]    rem_div;
	logic [2:0][EW-1:0]    rem_dec;
	logic [2:0][EW:0]      trial;
	logic                  err_in;
	logic                  slot_free;
	logic                  xfer;
	logic                  acc;

	assign crd_in[0] = site.payload.x_coord;
	assign crd_in[1] = site.payload.y_coord;
	assign crd_in[2] = site.payload.z_coord;

	assign slot_free  = !pv_q || prep_take;
	assign xfer       = busy_q && fin_q && slot_free;
	assign site.ready = !busy_q || xfer;
	assign acc        = site.valid && site.ready;

	always_comb begin
		err_in = 1'b0;
		for (int a = 0; a < 3; a++) begin
			if (PW'(crd_in[a]) >= PW'(extent[a])) begin
				err_in = 1'b1;
			end
			// one restoring step, dividend MSB first
			trial[a] = {rem_q[a], dvd_q[a][CRD_W-1]};
			if (trial[a] >= {1'b0, extent[a]}) begin
				rem_div[a] = EW'(trial[a] - {1'b0, extent[a]});
			end else begin
				rem_div[a] = EW'(trial[a]);
			end
			// step back by one with wrap
			if (rem_q[a] == '0) begin
				rem_dec[a] = extent[a] - EW'(1);
			end else begin
				rem_dec[a] = rem_q[a] - EW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			div_q  <= 1'b0;
			fin_q  <= 1'b0;
			cnt_q  <= '0;
			pv_q   <= 1'b0;
		end else begin
			if (acc) begin
				busy_q <= 1'b1;
				div_q  <= 1'b1;
				fin_q  <= 1'b0;
				cnt_q  <= CNT_W'(CRD_W - 1);
			end else if (busy_q && !fin_q) begin
				if (div_q) begin
					if (cnt_q == '0) begin
						div_q <= 1'b0;
						cnt_q <= CNT_W'(half - HW'(1));
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end else begin
					if (cnt_q == '0) begin
						fin_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
			end else if (xfer) begin
				busy_q <= 1'b0;
			end
			if (xfer) begin
				pv_q <= 1'b1;
			end else if (prep_take) begin
				pv_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			crd_q  <= crd_in;
			dvd_q  <= crd_in;
			rem_q  <= '0;
			slot_q <= site.payload.time_slot;
			err_q  <= err_in;
		end else if (busy_q && !fin_q) begin
			if (div_q) begin
				rem_q <= rem_div;
				for (int a = 0; a < 3; a++) begin
					dvd_q[a] <= {dvd_q[a][CRD_W-2:0], 1'b0};
				end
			end else begin
				rem_q <= rem_dec;
			end
		end
		if (xfer) begin
			pc_q <= crd_q;
			pw_q <= rem_q;
			ps_q <= slot_q;
			pe_q <= err_q;
		end
	end

	assign prep_valid = pv_q;
	assign prep_coord = pc_q;
	assign prep_start = pw_q;
	assign prep_slot  = ps_q;
	assign prep_err   = pe_q;

endmodule

>>> design/psag_seq.sv
// Run sequencer: walks centres, wrapped stencil points and loop corners.
module psag_seq #(
	parameter int unsigned MAX_EXTENT = 1024,
	parameter int unsigned MAX_HALF   = 4,
	localparam int unsigned EW = $clog2(MAX_EXTENT + 1),
	localparam int unsigned HW = $clog2(MAX_HALF + 1),
	localparam int unsigned PW = (psag_pkg::COORD_W > EW) ? psag_pkg::COORD_W : EW
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [2:0][EW-1:0]                extent,
	input  logic [HW-1:0]                     half,
	input  logic                              prep_valid,
	output logic                              prep_take,
	input  logic [2:0][psag_pkg::COORD_W-1:0] prep_coord,
	input  logic [2:0][EW-1:0]                prep_start,
	input  logic                              prep_slot,
	input  logic                              prep_err,
	input  logic                              adv,
	output logic                              req_valid,
	output psag_pkg::req_meta_t               req_meta,
	output logic [2:0][PW-1:0]                req_coord
);

	localparam int unsigned POS_W = psag_pkg::POS_W;

	psag_pkg::seq_phase_t phase_q, phase_d;
	psag_pkg::axis_t      axis_q, axis_d;
	logic [POS_W-1:0]     pos_q, pos_d;

	logic [EW-1:0]                         walk_q, walk_d;
	logic [2:0][psag_pkg::COORD_W-1:0]     crd_q;
	logic [2:0][EW-1:0]                    start_q;
	logic [2:0][EW-1:0]                    cor_q;
	logic                                  slot_q;
	logic                                  err_q;

	logic             is_last;
	logic             load;
	logic             cap_cor;
	logic [POS_W-1:0] pos_top;
	logic [POS_W-1:0] pos_cor;
	logic [EW-1:0]    walk_inc;
	psag_pkg::axis_t  other;

	// axes left over for a corner, in increasing order
	function automatic psag_pkg::axis_t other_axis(psag_pkg::axis_t a, logic j);
		psag_pkg::axis_t o;
		unique case (a)
			psag_pkg::AXIS_X: o = j ? psag_pkg::AXIS_Z : psag_pkg::AXIS_Y;
			psag_pkg::AXIS_Y: o = j ? psag_pkg::AXIS_Z : psag_pkg::AXIS_X;
			default:          o = j ? psag_pkg::AXIS_Y : psag_pkg::AXIS_X;
		endcase
		return o;
	endfunction

	assign pos_top  = POS_W'({half, 1'b0});
	assign pos_cor  = POS_W'(half - HW'(1));
	assign walk_inc = ((walk_q + EW'(1)) == extent[axis_q]) ? '0 : walk_q + EW'(1);
	assign other    = other_axis(axis_q, pos_q[0]);
	assign is_last  = (phase_q == psag_pkg::PH_CORNER) && (axis_q == psag_pkg::AXIS_Z)
		&& (pos_q == POS_W'(1));

	// outputs for the result currently offered
	always_comb begin
		req_valid = (phase_q != psag_pkg::PH_IDLE);
		for (int b = 0; b < 3; b++) begin
			req_coord[b] = PW'(crd_q[b]);
		end
		req_meta.kind        = psag_pkg::KIND_PAST;
		req_meta.axis        = psag_pkg::AXIS_X;
		req_meta.position    = '0;
		req_meta.slot        = slot_q;
		req_meta.range_error = err_q;
		req_meta.last        = is_last;
		unique case (phase_q)
			psag_pkg::PH_PAST: begin
				req_meta.slot = !slot_q;
			end
			psag_pkg::PH_NOW: begin
				req_meta.kind = psag_pkg::KIND_NOW;
			end
			psag_pkg::PH_STENCIL: begin
				req_meta.kind     = psag_pkg::KIND_STENCIL;
				req_meta.axis     = axis_q;
				req_meta.position = pos_q;
				req_coord[axis_q] = PW'(walk_q);
			end
			psag_pkg::PH_CORNER: begin
				req_meta.kind     = psag_pkg::KIND_CORNER;
				req_meta.axis     = axis_q;
				req_meta.position = pos_q;
				req_coord[other]  = PW'(cor_q[other]);
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		phase_d   = phase_q;
		axis_d    = axis_q;
		pos_d     = pos_q;
		walk_d    = walk_q;
		cap_cor   = 1'b0;
		prep_take = prep_valid && ((phase_q == psag_pkg::PH_IDLE) || (is_last && adv));
		load      = prep_take;
		if (load) begin
			phase_d = psag_pkg::PH_PAST;
		end else if (phase_q == psag_pkg::PH_IDLE) begin
			phase_d = psag_pkg::PH_IDLE;
		end else if (adv) begin
			unique case (phase_q)
				psag_pkg::PH_PAST: begin
					phase_d = psag_pkg::PH_NOW;
				end
				psag_pkg::PH_NOW: begin
					phase_d = psag_pkg::PH_STENCIL;
					axis_d  = psag_pkg::AXIS_X;
					pos_d   = '0;
					walk_d  = start_q[0];
				end
				psag_pkg::PH_STENCIL: begin
					cap_cor = (pos_q == pos_cor);
					if (pos_q == pos_top) begin
						pos_d = '0;
						unique case (axis_q)
							psag_pkg::AXIS_X: begin
								axis_d = psag_pkg::AXIS_Y;
								walk_d = start_q[1];
							end
							psag_pkg::AXIS_Y: begin
								axis_d = psag_pkg::AXIS_Z;
								walk_d = start_q[2];
							end
							default: begin
								axis_d  = psag_pkg::AXIS_X;
								phase_d = psag_pkg::PH_CORNER;
							end
						endcase
					end else begin
						pos_d  = pos_q + POS_W'(1);
						walk_d = walk_inc;
					end
				end
				psag_pkg::PH_CORNER: begin
					if (is_last) begin
						phase_d = psag_pkg::PH_IDLE;
					end else if (pos_q == POS_W'(1)) begin
						pos_d = '0;
						axis_d = (axis_q == psag_pkg::AXIS_X) ? psag_pkg::AXIS_Y
							: psag_pkg::AXIS_Z;
					end else begin
						pos_d = POS_W'(1);
					end
				end
				default: begin
					phase_d = psag_pkg::PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= psag_pkg::PH_IDLE;
			axis_q  <= psag_pkg::AXIS_X;
			pos_q   <= '0;
		end else begin
			phase_q <= phase_d;
			axis_q  <= axis_d;
			pos_q   <= pos_d;
		end
	end

	always_ff @(posedge clk) begin
		walk_q <= walk_d;
		if (cap_cor) begin
			cor_q[axis_q] <= walk_q;
		end
		if (load) begin
			crd_q   <= prep_coord;
			start_q <= prep_start;
			slot_q  <= prep_slot;
			err_q   <= prep_err;
		end
	end

endmodule

>>> design/psag_addr_pipe.sv
// Three-stage site index and offset pipeline ending in the output register.
module psag_addr_pipe #(
	parameter int unsigned MAX_EXTENT     = 1024,
	parameter int unsigned MAX_COMPONENTS = 64,
	localparam int unsigned EW = $clog2(MAX_EXTENT + 1),
	localparam int unsigned MW = $clog2(MAX_COMPONENTS + 1),
	localparam int unsigned PW = (psag_pkg::COORD_W > EW) ? psag_pkg::COORD_W : EW
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [2:0][EW-1:0]  extent,
	input  logic [MW-1:0]       scalar_w,
	input  logic [MW-1:0]       vector_w,
	input  logic                req_valid,
	input  psag_pkg::req_meta_t req_meta,
	input  logic [2:0][PW-1:0]  req_coord,
	output logic                adv,
	psag_stream_if.source       result
);

	localparam int unsigned OFS_W = psag_pkg::OFS_W;
	localparam int unsigned W1    = PW + 1;
	localparam int unsigned W2    = (W1 + EW + 1 < OFS_W) ? W1 + EW + 1 : OFS_W;
	localparam int unsigned W3    = (W2 + EW + 1 < OFS_W) ? W2 + EW + 1 : OFS_W;

	logic                v_s1, v_s2, v_s3;
	psag_pkg::req_meta_t meta_s1, meta_s2;
	logic [W2-1:0]       m1_s1;
	logic [PW-1:0]       z_s1;
	logic [W3-1:0]       idx_s2;
	psag_pkg::result_t   res_s3;

	logic [W1-1:0]      a1;
	logic [W1+EW-1:0]   pr1;
	logic [W2-1:0]      m1;
	logic [W2+EW-1:0]   pr2;
	logic [W3-1:0]      idx;
	logic [W3+MW-1:0]   prs;
	logic [W3+MW-1:0]   prv;

	// whole pipe moves together; it holds only while the output is stalled
	assign adv = !v_s3 || result.ready;

	// stage 1: (t*nx + x)*ny + y
	assign a1  = (req_meta.slot ? W1'(extent[0]) : W1'(0)) + W1'(req_coord[0]);
	assign pr1 = a1 * extent[1];
	assign m1  = W2'(pr1) + W2'(req_coord[1]);

	// stage 2: *nz + z
	assign pr2 = m1_s1 * extent[2];
	assign idx = W3'(pr2) + W3'(z_s1);

	// stage 3: component scaling
	assign prs = idx_s2 * scalar_w;
	assign prv = idx_s2 * vector_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s1 <= req_meta;
			m1_s1   <= m1;
			z_s1    <= req_coord[2];
			meta_s2 <= meta_s1;
			idx_s2  <= idx;
			res_s3.kind          <= meta_s2.kind;
			res_s3.axis          <= meta_s2.axis;
			res_s3.position      <= meta_s2.position;
			res_s3.scalar_offset <= (meta_s2.kind == psag_pkg::KIND_CORNER) ? '0
				: OFS_W'(prs);
			res_s3.vector_offset <= OFS_W'(prv);
			res_s3.range_error   <= meta_s2.range_error;
			res_s3.last          <= meta_s2.last;
		end
	end

	assign result.valid   = v_s3;
	assign result.payload = res_s3;

endmodule

>>> design/periodic_stencil_address_gen_core.sv
// Periodic-boundary stencil address generator, top level.
// Path from site accept to the first result: bit-serial remainder over the 10 coordinate
//   bits, S wrap-back steps, handoff, sequencer, three pipeline stages.
// Throughput: one result per cycle unless the output stalls; 6S + 11 results per site (17 at
//   S = 1); the next site is prepared while the current run streams out, so runs abut.
// Reset: configuration registers return to their defaults, all pipeline valids clear;
//   no stores, so no clearing pass.
module periodic_stencil_address_gen_core #(
	parameter int unsigned MAX_EXTENT     = 1024,
	parameter int unsigned MAX_HALF       = 4,
	parameter int unsigned MAX_COMPONENTS = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	psag_stream_if.sink   cfg,
	psag_stream_if.sink   site,
	psag_stream_if.source result
);

	localparam int unsigned EW = $clog2(MAX_EXTENT + 1);
	localparam int unsigned MW = $clog2(MAX_COMPONENTS + 1);
	localparam int unsigned HW = $clog2(MAX_HALF + 1);
	localparam int unsigned PW = (psag_pkg::COORD_W > EW) ? psag_pkg::COORD_W : EW;

	// effective (saturated) configuration
	logic [2:0][EW-1:0] extent;
	logic [MW-1:0]      scalar_w;
	logic [MW-1:0]      vector_w;
	logic [HW-1:0]      half;

	// front end to sequencer handoff
	logic                              prep_valid;
	logic                              prep_take;
	logic [2:0][psag_pkg::COORD_W-1:0] prep_coord;
	logic [2:0][EW-1:0]                prep_start;
	logic                              prep_slot;
	logic                              prep_err;

	// sequencer to address pipeline
	logic                req_valid;
	psag_pkg::req_meta_t req_meta;
	logic [2:0][PW-1:0]  req_coord;
	logic                adv;

	psag_cfg_regs #(
		.MAX_EXTENT     (MAX_EXTENT),
		.MAX_HALF       (MAX_HALF),
		.MAX_COMPONENTS (MAX_COMPONENTS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.extent   (extent),
		.scalar_w (scalar_w),
		.vector_w (vector_w),
		.half     (half)
	);

	// Per site: c mod n per axis, one bit a cycle, then S decrements with wrap
	// give the first stencil coordinate (c - S) mod n. Works on the next site
	// while the sequencer is busy with the current one.
	psag_prep #(
		.MAX_EXTENT (MAX_EXTENT),
		.MAX_HALF   (MAX_HALF)
	) u_prep (
		.clk        (clk),
		.arst_n     (arst_n),
		.site       (site),
		.extent     (extent),
		.half       (half),
		.prep_valid (prep_valid),
		.prep_take  (prep_take),
		.prep_coord (prep_coord),
		.prep_start (prep_start),
		.prep_slot  (prep_slot),
		.prep_err   (prep_err)
	);

	// Emits one site request per cycle unless adv is low. Stencil coordinates
	// step +1 with wrap; the shift -1 point is kept per axis for the loop corners.
	psag_seq #(
		.MAX_EXTENT (MAX_EXTENT),
		.MAX_HALF   (MAX_HALF)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.extent     (extent),
		.half       (half),
		.prep_valid (prep_valid),
		.prep_take  (prep_take),
		.prep_coord (prep_coord),
		.prep_start (prep_start),
		.prep_slot  (prep_slot),
		.prep_err   (prep_err),
		.adv        (adv),
		.req_valid  (req_valid),
		.req_meta   (req_meta),
		.req_coord  (req_coord)
	);

	// index = ((t*nx + x)*ny + y)*nz + z, one multiply per stage, then scaled
	// by the component counts into the output register
	psag_addr_pipe #(
		.MAX_EXTENT     (MAX_EXTENT),
		.MAX_COMPONENTS (MAX_COMPONENTS)
	) u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.extent    (extent),
		.scalar_w  (scalar_w),
		.vector_w  (vector_w),
		.req_valid (req_valid),
		.req_meta  (req_meta),
		.req_coord (req_coord),
		.adv       (adv),
		.result    (result)
	);

endmodule

>>> tb/periodic_stencil_address_gen_core_test.sv
// Self-checking bench for the periodic stencil address generator: table-driven and random sites.
module periodic_stencil_address_gen_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	// limits of the block as built here (default parameters)
	localparam int MAX_EXTENT     = 1024;
	localparam int MAX_HALF       = 4;
	localparam int MAX_COMPONENTS = 64;

	// indexes outside the register map; writes to them must change nothing
	localparam logic [psag_pkg::REG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [psag_pkg::REG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	localparam int CYCLE_LIMIT   = 3000000;
	localparam int SETTLE_CYCLES = 64;     // well past the site-to-result latency
	localparam int HOLD_CYCLES   = 400;    // long receiver hold-off
	localparam int RAND_PHASES   = 10;
	localparam int SITES_PER_PH  = 48;
	localparam int STEADY_PHASE  = 3;      // no idling on either side
	localparam int HOLD_PHASE    = 5;      // receiver hold-off while sites keep coming

	typedef enum logic {
		ROW_CFG,
		ROW_SITE
	} row_op_t;

	// one row of the directed table; past_vec / past_err are typed in only where
	// the past-centre result is obvious by hand (chk set)
	typedef struct packed {
		row_op_t                         op;
		logic [psag_pkg::REG_IDX_W-1:0]  idx;
		logic [psag_pkg::CFG_DATA_W-1:0] data;
		logic [psag_pkg::COORD_W-1:0]    x;
		logic [psag_pkg::COORD_W-1:0]    y;
		logic [psag_pkg::COORD_W-1:0]    z;
		logic                            t;
		logic                            chk;
		logic [psag_pkg::OFS_W-1:0]      past_vec;
		logic                            past_err;
	} dir_row_t;

	localparam int DIR_ROWS = 30;
	localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
		// reset extents 16x16x16, one component each, S = 1
		'{ROW_SITE, psag_pkg::REG_SIZE_X, 11'd0,
			10'd0,    10'd0,    10'd0,    1'b0, 1'b1, 37'd4096,   1'b0},
		'{ROW_SITE, psag_pkg::REG_SIZE_X, 11'd0,
			10'd15,   10'd15,   10'd15,   1'b1, 1'b1, 37'd4095,   1'b0},
		'{ROW_SITE, psag_pkg::REG_SIZE_X, 11'd0,
			10'd16,   10'd0,    10'd0,    1'b0, 1'b1, 37'd8192,   1'b1},
		'{ROW_SITE, psag_pkg::REG_SIZE_X, 11'd0,
			10'd1023, 10'd1023, 10'd1023, 1'b1, 1'b1, 37'd279279, 1'b1},
		'{ROW_SITE, psag_pkg::REG_SIZE_X, 11'd0,
			10'd0,    10'd15,   10'd16,   1'b0, 1'b0, 37'd0,      1'b0},
		// single-site grid, widest components, widest stencil
		'{ROW_CFG, psag_pkg::REG_SIZE_X,       11'd1,
			10'd0, 10'd0, 10'd0, 1'b0, 1'b0, 37'd0, 1'b0},
		'{ROW_CFG, psag_pkg::REG_SIZE_Y,       11'd1,
			10'd0, 10'd0, 10'd0, 1'b0, 1'b0, 37'd0, 1'b0},
		'{ROW_CFG, psag_pkg::REG_SIZE_Z,       11'd1,
			10'd0, 10'd0, 10'd0, 1'b0, 1'b0, 37'd0, 1'b0},
		'{ROW_CFG, psag_pkg::REG_SCALAR_WIDTH, 11'd64,
			10'd0, 10'd0, 10'd0, 1'b0, 1'b0, 37'd0, 1'b0},
		'{ROW_CFG, psag_pkg::REG_VECTOR_WIDTH, 11'd64,
			10'd0, 10'd0, 10'd0, 1'b0, 1'b0, 37'd0, 1'b0},
		'{ROW_CFG, psag_pkg::REG_STENCIL_HALF, 11'd4,
			10'd0, 10'd0, 10'd0, 1'b0, 1'b0, 37'd0, 1'b0},
		'{ROW_SITE, psag_pkg::REG_SIZE_X, 11'd0,
			10'd0, 10'd0, 10'd0, 1'b0, 1'b1, 37'd64, 1'b0},
		'{ROW_SITE, psag_pkg::REG_SIZE_X, 11'd0,
			10'd0, 10'd0, 10'd0, 1'b1, 1'b1, 37'd0,  1'b0},
		'{ROW_SITE, psag_pkg::REG_SIZE_X, 11'd0,
			10'd1, 10'd0, 10'd0, 1'b0, 1'b0, 37'd0,  1'b0},
		// out-of-range register values saturate; spare indexes are ignored
		'{ROW_CFG, psag_pkg::REG_SIZE_X,       11'd2047,
			10'd0, 10'd0, 10'd0, 1'b0, 1'b0, 37'd0, 1'b0},
		'{ROW_CFG, psag_pkg::REG_SIZE_Y,       11'd1024,
			10'd0, 10'd0, 10'd0, 1'b0, 1'b0, 37'd0, 1'b0},
		'{ROW_CFG, psag_pkg::REG_SIZE_Z,       11'd0,
			10'd0, 10'd0, 10'd0, 1'b0, 1'b0, 37'd0, 1'b0},
		'{ROW_CFG, psag_pkg::REG_SCALAR_WIDTH, 11'd0,
			10'd0, 10'd0, 10'd0, 1'b0, 1'b0, 37'd0, 1'b0},
		'{ROW_CFG, psag_pkg::REG_VECTOR_WIDTH, 11'd127,
			10'd0, 10'd0, 10'd0, 1'b0, 1'b0, 37'd0, 1'b0},
		'{ROW_CFG, psag_pkg::REG_STENCIL_HALF, 11'd7,
			10'd0, 10'd0, 10'd0, 1'b0, 1'b0, 37'd0, 1'b0},
		'{ROW_CFG, REG_SPARE_6,                11'd2047,
			10'd0, 10'd0, 10'd0, 1'b0, 1'b0, 37'd0, 1'b0},
		'{ROW_CFG, REG_SPARE_7,                11'd0,
			10'd0, 10'd0, 10'd0, 1'b0, 1'b0, 37'd0, 1'b0},
		'{ROW_SITE, psag_pkg::REG_SIZE_X, 11'd0,
			10'd1023, 10'd1023, 10'd0,    1'b1, 1'b1, 37'd67108800, 1'b0},
		'{ROW_SITE, psag_pkg::REG_SIZE_X, 11'd0,
			10'd0,    10'd0,    10'd0,    1'b0, 1'b1, 37'd67108864, 1'b0},
		'{ROW_SITE, psag_pkg::REG_SIZE_X, 11'd0,
			10'd512,  10'd7,    10'd0,    1'b0, 1'b0, 37'd0,        1'b0},
		'{ROW_SITE, psag_pkg::REG_SIZE_X, 11'd0,
			10'd3,    10'd1023, 10'd1023, 1'b1, 1'b0, 37'd0,        1'b0},
		// full 1024^3 grid: largest offsets; half width zero counts as one
		'{ROW_CFG, psag_pkg::REG_SIZE_Z,       11'd1024,
			10'd0, 10'd0, 10'd0, 1'b0, 1'b0, 37'd0, 1'b0},
		'{ROW_CFG, psag_pkg::REG_STENCIL_HALF, 11'd0,
			10'd0, 10'd0, 10'd0, 1'b0, 1'b0, 37'd0, 1'b0},
		'{ROW_SITE, psag_pkg::REG_SIZE_X, 11'd0,
			10'd1023, 10'd1023, 10'd1023, 1'b0, 1'b1, 37'd137438953408, 1'b0},
		'{ROW_SITE, psag_pkg::REG_SIZE_X, 11'd0,
			10'd0,    10'd0,    10'd0,    1'b1, 1'b1, 37'd0, 1'b0}
	};

	logic clk;
	logic arst_n;

	psag_stream_if #(.T(psag_pkg::cfg_write_t)) cfg_ch ();
	psag_stream_if #(.T(psag_pkg::site_t))      site_ch ();
	psag_stream_if #(.T(psag_pkg::result_t))    result_ch ();

	periodic_stencil_address_gen_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.site   (site_ch),
		.result (result_ch)
	);

	// shadow copy of the register file, raw bits as written
	logic [psag_pkg::SIZE_W-1:0] size_reg [3];
	logic [psag_pkg::COMP_W-1:0] scalar_reg;
	logic [psag_pkg::COMP_W-1:0] vector_reg;
	logic [psag_pkg::HALF_W-1:0] half_reg;

	// effective (saturated) settings, refreshed per site
	int ext_x, ext_y, ext_z, comp_s, comp_v, half_s;

	psag_pkg::result_t stencil_run_q [$];   // offsets still owed by the block, oldest first
	int                mismatch_cnt;
	int                cycle_cnt;
	bit                steady;              // both sides stop idling
	bit                hold_req;            // asks the result side for a long hold-off

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// Address prediction
	// ---------------------------------------------------------------------
	function automatic int sat(int v, int hi);
		if (v == 0)
			return 1;
		return (v > hi) ? hi : v;
	endfunction

	// true modulo, so a shift of -1 from 0 lands on n-1
	function automatic int wrap(int c, int d, int n);
		int r;
		r = (c + d) % n;
		if (r < 0)
			r += n;
		return r;
	endfunction

	function automatic void push_point(psag_pkg::kind_t k, psag_pkg::axis_t ax, int pos,
		int t, int px, int py, int pz, logic err);
		longint            idx;
		longint            ofs;
		psag_pkg::result_t r;
		idx = ((longint'(t) * ext_x + px) * ext_y + py) * ext_z + pz;
		r.kind     = k;
		r.axis     = ax;
		r.position = psag_pkg::POS_W'(pos);
		ofs = idx * comp_s;
		r.scalar_offset = (k == psag_pkg::KIND_CORNER) ? '0 : psag_pkg::OFS_W'(ofs);
		ofs = idx * comp_v;
		r.vector_offset = psag_pkg::OFS_W'(ofs);
		r.range_error   = err;
		// the z-axis second corner always closes the run
		r.last = (k == psag_pkg::KIND_CORNER) && (ax == psag_pkg::AXIS_Z) && (pos == 1);
		stencil_run_q.push_back(r);
	endfunction

	function automatic void predict_run(psag_pkg::site_t s);
		int   cx, cy, cz, tn, px, py, pz, o;
		logic err;
		ext_x  = sat(int'(size_reg[0]), MAX_EXTENT);
		ext_y  = sat(int'(size_reg[1]), MAX_EXTENT);
		ext_z  = sat(int'(size_reg[2]), MAX_EXTENT);
		comp_s = sat(int'(scalar_reg), MAX_COMPONENTS);
		comp_v = sat(int'(vector_reg), MAX_COMPONENTS);
		half_s = sat(int'(half_reg), MAX_HALF);
		cx = int'(s.x_coord);
		cy = int'(s.y_coord);
		cz = int'(s.z_coord);
		tn = int'(s.time_slot);
		err = (cx >= ext_x) || (cy >= ext_y) || (cz >= ext_z);

		push_point(psag_pkg::KIND_PAST, psag_pkg::AXIS_X, 0, tn ^ 1, cx, cy, cz, err);
		push_point(psag_pkg::KIND_NOW, psag_pkg::AXIS_X, 0, tn, cx, cy, cz, err);

		// stencil: raw coordinate where not shifted, wrapped where shifted
		for (int a = 0; a < 3; a++) begin
			for (int i = 0; i <= 2 * half_s; i++) begin
				px = cx;
				py = cy;
				pz = cz;
				case (a)
					0: px = wrap(cx, i - half_s, ext_x);
					1: py = wrap(cy, i - half_s, ext_y);
					default: pz = wrap(cz, i - half_s, ext_z);
				endcase
				push_point(psag_pkg::KIND_STENCIL, psag_pkg::axis_t'(a), i, tn, px, py, pz,
					err);
			end
		end

		// corners: step back one along each of the other two axes, low axis first
		for (int a = 0; a < 3; a++) begin
			for (int j = 0; j < 2; j++) begin
				px = cx;
				py = cy;
				pz = cz;
				o = (a == 0) ? j + 1 : (a == 1) ? 2 * j : j;
				case (o)
					0: px = wrap(cx, -1, ext_x);
					1: py = wrap(cy, -1, ext_y);
					default: pz = wrap(cz, -1, ext_z);
				endcase
				push_point(psag_pkg::KIND_CORNER, psag_pkg::axis_t'(a), j, tn, px, py, pz,
					err);
			end
		end
	endfunction

	// ---------------------------------------------------------------------
	// Checking
	// ---------------------------------------------------------------------
	task automatic report_mismatch(input string what, input longint unsigned got,
		input longint unsigned want);
		mismatch_cnt++;
		$display("%0t ns: %s: got %0d, expected %0d", $realtime, what, got, want);
	endtask

	// values sampled at the edge are the pre-edge ones, so no race with the block
	always @(posedge clk) begin
		psag_pkg::result_t got, want;
		if (result_ch.valid && result_ch.ready) begin
			got = result_ch.payload;
			if (stencil_run_q.size() == 0) begin
				report_mismatch("result with nothing pending, vector offset",
					got.vector_offset, 0);
			end else begin
				want = stencil_run_q.pop_front();
				if (got.kind !== want.kind)
					report_mismatch("kind", got.kind, want.kind);
				if (got.axis !== want.axis)
					report_mismatch("axis", got.axis, want.axis);
				if (got.position !== want.position)
					report_mismatch("position", got.position, want.position);
				if (got.scalar_offset !== want.scalar_offset)
					report_mismatch("scalar_offset", got.scalar_offset, want.scalar_offset);
				if (got.vector_offset !== want.vector_offset)
					report_mismatch("vector_offset", got.vector_offset, want.vector_offset);
				if (got.range_error !== want.range_error)
					report_mismatch("range_error", got.range_error, want.range_error);
				if (got.last !== want.last)
					report_mismatch("last", got.last, want.last);
			end
		end
	end

	// run-away guard
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("periodic_stencil_address_gen_core verification failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Result side: random back-pressure, plus the long hold-off on request
	// ---------------------------------------------------------------------
	initial begin : result_sink
		int r;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (steady) begin
				result_ch.ready <= 1'b1;
				@(posedge clk);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					result_ch.ready <= 1'b1;
					repeat ($urandom_range(1, 24)) @(posedge clk);
				end else if (r < 92) begin
					result_ch.ready <= 1'b0;
					repeat ($urandom_range(1, 3)) @(posedge clk);
				end else begin
					result_ch.ready <= 1'b0;
					repeat ($urandom_range(8, 40)) @(posedge clk);
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Site and register side
	// ---------------------------------------------------------------------
	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [psag_pkg::CFG_DATA_W-1:0] pick_size();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 11'd1;
			2: return 11'd1024;
			3: return psag_pkg::CFG_DATA_W'($urandom_range(1025, 2047));
			4: return psag_pkg::CFG_DATA_W'($urandom_range(1, 1024));
			default: return psag_pkg::CFG_DATA_W'($urandom_range(1, 40));
		endcase
	endfunction

	function automatic logic [psag_pkg::CFG_DATA_W-1:0] pick_comp();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return psag_pkg::CFG_DATA_W'($urandom_range(65, 127));
			2: return 11'd64;
			default: return psag_pkg::CFG_DATA_W'($urandom_range(1, 64));
		endcase
	endfunction

	// mostly well inside or on the edge of the grid; now and then past it
	function automatic psag_pkg::site_t pick_site();
		psag_pkg::site_t s;
		int              ext [3];
		int              crd [3];
		int              bad;
		ext[0] = sat(int'(size_reg[0]), MAX_EXTENT);
		ext[1] = sat(int'(size_reg[1]), MAX_EXTENT);
		ext[2] = sat(int'(size_reg[2]), MAX_EXTENT);
		for (int a = 0; a < 3; a++) begin
			case ($urandom_range(0, 9))
				0: crd[a] = 0;
				1: crd[a] = ext[a] - 1;
				default: crd[a] = $urandom_range(0, ext[a] - 1);
			endcase
		end
		if ($urandom_range(0, 99) < 12) begin
			bad = $urandom_range(0, 2);
			crd[bad] = (ext[bad] < 1024) ? $urandom_range(ext[bad], 1023)
			                             : $urandom_range(0, 1023);
		end
		s.x_coord   = psag_pkg::COORD_W'(crd[0]);
		s.y_coord   = psag_pkg::COORD_W'(crd[1]);
		s.z_coord   = psag_pkg::COORD_W'(crd[2]);
		s.time_slot = 1'($urandom_range(0, 1));
		return s;
	endfunction

	// leaves valid high; the caller lowers it once the burst of writes is done
	task automatic write_reg(input logic [psag_pkg::REG_IDX_W-1:0] idx,
		input logic [psag_pkg::CFG_DATA_W-1:0] data);
		psag_pkg::cfg_write_t w;
		w.index = idx;
		w.data  = data;
		cfg_ch.valid   <= 1'b1;
		cfg_ch.payload <= w;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		case (idx)
			psag_pkg::REG_SIZE_X:       size_reg[0] = data;
			psag_pkg::REG_SIZE_Y:       size_reg[1] = data;
			psag_pkg::REG_SIZE_Z:       size_reg[2] = data;
			psag_pkg::REG_SCALAR_WIDTH: scalar_reg = data[psag_pkg::COMP_W-1:0];
			psag_pkg::REG_VECTOR_WIDTH: vector_reg = data[psag_pkg::COMP_W-1:0];
			psag_pkg::REG_STENCIL_HALF: half_reg = data[psag_pkg::HALF_W-1:0];
			default: ;
		endcase
	endtask

	// offers one site after an optional gap; predicts its run once accepted
	task automatic send_site(input psag_pkg::site_t s, input int gap);
		if (gap > 0) begin
			site_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		site_ch.valid   <= 1'b1;
		site_ch.payload <= s;
		@(posedge clk);
		while (!site_ch.ready) @(posedge clk);
		predict_run(s);
	endtask

	// sender pauses until every owed offset has come back
	task automatic drain_runs();
		site_ch.valid <= 1'b0;
		while (stencil_run_q.size() != 0) @(posedge clk);
	endtask

	initial begin : stimulus
		psag_pkg::site_t   s;
		dir_row_t          row;
		psag_pkg::result_t first;
		int                base;

		arst_n         <= 1'b0;
		cfg_ch.valid   <= 1'b0;
		cfg_ch.payload <= '0;
		site_ch.valid  <= 1'b0;
		site_ch.payload <= '0;
		mismatch_cnt = 0;
		cycle_cnt    = 0;
		steady       = 1'b0;
		hold_req     = 1'b0;
		size_reg[0]  = 11'd16;
		size_reg[1]  = 11'd16;
		size_reg[2]  = 11'd16;
		scalar_reg   = 7'd1;
		vector_reg   = 7'd1;
		half_reg     = 3'd1;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: register writes only with the block drained
		for (int n = 0; n < DIR_ROWS; n++) begin
			row = DIR_TABLE[n];
			if (row.op == ROW_CFG) begin
				drain_runs();
				write_reg(row.idx, row.data);
			end else begin
				cfg_ch.valid <= 1'b0;
				s.x_coord   = row.x;
				s.y_coord   = row.y;
				s.z_coord   = row.z;
				s.time_slot = row.t;
				send_site(s, pick_gap());
				// the new run sits at the tail: 2 centres, 3 axes of 2S + 1 stencil points, 6 corners
				base = stencil_run_q.size() - (6 * half_s + 11);
				// hand-worked past centre takes the place of the computed one
				if (row.chk) begin
					first = stencil_run_q[base];
					first.vector_offset = row.past_vec;
					first.range_error   = row.past_err;
					stencil_run_q[base] = first;
				end
			end
		end

		// random phases, each under its own register setting
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			drain_runs();
			steady = (ph == STEADY_PHASE);
			if (ph == 0) begin
				// largest of everything
				write_reg(psag_pkg::REG_SIZE_X, 11'd1024);
				write_reg(psag_pkg::REG_SIZE_Y, 11'd1024);
				write_reg(psag_pkg::REG_SIZE_Z, 11'd1024);
				write_reg(psag_pkg::REG_SCALAR_WIDTH, 11'd64);
				write_reg(psag_pkg::REG_VECTOR_WIDTH, 11'd64);
				write_reg(psag_pkg::REG_STENCIL_HALF, 11'd4);
			end else if (ph == 1) begin
				// smallest, partly through zero values
				write_reg(psag_pkg::REG_SIZE_X, 11'd1);
				write_reg(psag_pkg::REG_SIZE_Y, '0);
				write_reg(psag_pkg::REG_SIZE_Z, 11'd1);
				write_reg(psag_pkg::REG_SCALAR_WIDTH, '0);
				write_reg(psag_pkg::REG_VECTOR_WIDTH, 11'd1);
				write_reg(psag_pkg::REG_STENCIL_HALF, '0);
			end else begin
				write_reg(psag_pkg::REG_SIZE_X, pick_size());
				write_reg(psag_pkg::REG_SIZE_Y, pick_size());
				write_reg(psag_pkg::REG_SIZE_Z, pick_size());
				write_reg(psag_pkg::REG_SCALAR_WIDTH, pick_comp());
				write_reg(psag_pkg::REG_VECTOR_WIDTH, pick_comp());
				write_reg(psag_pkg::REG_STENCIL_HALF,
					psag_pkg::CFG_DATA_W'($urandom_range(0, 7)));
				if ($urandom_range(0, 2) == 0)
					write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7,
						psag_pkg::CFG_DATA_W'($urandom));
			end
			cfg_ch.valid <= 1'b0;
			@(posedge clk);

			for (int k = 0; k < SITES_PER_PH; k++) begin
				// hold-off lands mid-phase so the block backs up into the site port
				if (ph == HOLD_PHASE && k == 6)
					hold_req = 1'b1;
				send_site(pick_site(), pick_gap());
			end
		end

		drain_runs();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("periodic_stencil_address_gen_core verification clean");
		else
			$display("periodic_stencil_address_gen_core verification failed");
		$finish;
	end

endmodule
